@@ hw/rtl/amiv_pkg.sv @@
// ============================================================================
// amiv_pkg : shared types and fixed-point helpers for the affine inverse
// Q16.16 saturating multiply, add and negate; pipeline stage structs.
// ============================================================================
package amiv_pkg;

  localparam int EW       = 32;            // entry width
  localparam int FB       = 16;            // fraction bits
  localparam int PW       = 2 * EW;        // full product width
  localparam int SW       = PW - FB;       // product width after the shift
  localparam int CPI      = 4;             // cycles between accepted items
  localparam int CW       = $clog2(CPI);
  localparam int DIV_BITS = 2 * FB + 1;    // quotient bits of 2^(2*FB) / |det|
  localparam int DIV_STEP = 3;             // quotient bits per divider stage
  localparam int DIV_STG  = (DIV_BITS + DIV_STEP - 1) / DIV_STEP;

  localparam logic [1:0] ROW_TR = 2'd3;    // translation row code

  typedef logic signed [EW-1:0] q_t;
  typedef logic [EW-1:0]        mag_t;

  localparam q_t QMAX = {1'b0, {(EW-1){1'b1}}};
  localparam q_t QMIN = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    logic sat;
    q_t   val;
  } sq_t;

  typedef q_t [2:0] vec_t;
  typedef vec_t [2:0] mat_t;

  typedef struct packed {
    q_t e11;
    q_t e12;
    q_t e13;
    q_t e21;
    q_t e22;
    q_t e23;
    q_t e31;
    q_t e32;
    q_t e33;
    q_t off_x;
    q_t off_y;
    q_t off_z;
  } in_t;

  typedef struct packed {
    logic [1:0] row_select;
    q_t         out_a;
    q_t         out_b;
    q_t         out_c;
    logic       singular;
    logic       saturated;
    logic       last_row;
  } out_t;

  // cofactor stage -> determinant stage
  typedef struct packed {
    logic       vld;
    mat_t       adj;
    logic [2:0] rsat;
    vec_t       erow;
    vec_t       off;
  } cof_t;

  // determinant stage -> divider
  typedef struct packed {
    logic       vld;
    mat_t       adj;
    logic [2:0] rsat;
    vec_t       off;
    logic       sing;
    logic       dneg;
    mag_t       dmag;
    logic       dsat;
  } det_t;

  // divider -> scaling stages
  typedef struct packed {
    logic       vld;
    mat_t       adj;
    logic [2:0] rsat;
    vec_t       off;
    logic       sing;
    logic       dsat;
    q_t         recip;
  } rcp_t;

  // scaling stages -> row serializer
  typedef struct packed {
    logic       vld;
    mat_t       inv;
    vec_t       tr;
    logic       sing;
    logic       dsat;
    logic [3:0] rsat;
  } res_t;

  function automatic mag_t mag(q_t a);
    return a[EW-1] ? mag_t'(~a + 1'b1) : mag_t'(a);
  endfunction

  // clip a magnitude to the signed range, then apply the sign
  function automatic sq_t lim_mag(logic neg, logic [SW-1:0] m);
    logic [SW-1:0] lim;
    mag_t          mw;
    sq_t           r;
    lim   = {{(SW-EW){1'b0}}, QMAX} + SW'(neg);
    r.sat = (m > lim);
    mw    = r.sat ? lim[EW-1:0] : m[EW-1:0];
    r.val = neg ? q_t'(~mw + 1'b1) : q_t'(mw);
    return r;
  endfunction

  function automatic sq_t mulq(q_t a, q_t b);
    logic [PW-1:0] p;
    p = PW'(mag(a)) * PW'(mag(b));
    return lim_mag(a[EW-1] ^ b[EW-1], p[PW-1:FB]);
  endfunction

  function automatic sq_t sat_add(q_t a, q_t b);
    logic [EW:0] s;
    sq_t         r;
    s = {a[EW-1], a} + {b[EW-1], b};
    if (s[EW] != s[EW-1]) begin
      r.sat = 1'b1;
      r.val = s[EW] ? QMIN : QMAX;
    end else begin
      r.sat = 1'b0;
      r.val = q_t'(s[EW-1:0]);
    end
    return r;
  endfunction

  function automatic sq_t sat_neg(q_t a);
    sq_t r;
    if (a == QMIN) begin
      r.sat = 1'b1;
      r.val = QMAX;
    end else begin
      r.sat = 1'b0;
      r.val = q_t'(-a);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/affine_matrix_inverse.sv @@
// ============================================================================
// affine_matrix_inverse : inverse of a row-vector affine transform, Q16.16
// Cofactor adjugate, determinant, pipelined reciprocal, four result rows.
// ============================================================================
// Usage:
//   Input: drive in_item (3x3 linear part plus translation row) and raise
//   start; the transfer happens on a clock edge where start is high and busy
//   is low. busy rises after each transfer and stays high until the throttle
//   has counted down, so matrices are taken no faster than their four result rows.
//   Output: four rows per matrix on out_item, each marked by out_valid for
//   exactly one cycle, rows 0, 1, 2 (linear part) then the translation row
//   with last_row set. The receiver cannot stall; it must take each row.
//   Rows of one matrix leave back to back on the single result channel,
//   which is what the input throttle is paced to.
//   Pipeline: 2 cofactor stages, 2 determinant stages, an 11-stage divider
//   (3 quotient bits per stage) plus a reciprocal clip stage, 4 scaling
//   stages and the row serializer. Everything advances every cycle.
//   A zero determinant gives zero rows with singular set.
//   Reset (rst_n low, synchronous) clears all valid bits and the throttle;
//   matrices in flight are dropped.
// ============================================================================
module affine_matrix_inverse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  amiv_pkg::in_t   in_item,
  output logic            out_valid,
  output amiv_pkg::out_t  out_item
);

  logic                      acc;
  logic [amiv_pkg::CW-1:0]   thr_r, thr_nxt;
  amiv_pkg::cof_t            cof;
  amiv_pkg::det_t            det;
  amiv_pkg::rcp_t            rcp;
  amiv_pkg::res_t            res;
  amiv_pkg::res_t            hold_r;
  logic [1:0]                row_r, row_nxt;
  logic                      ov_r, ov_nxt;

  // throttle: busy blocks a new transfer until the counter is back at zero
  assign busy = (thr_r != '0);
  assign acc  = start & ~busy;

  always_comb begin
    if (acc) begin
      thr_nxt = amiv_pkg::CW'(amiv_pkg::CPI - 1);
    end else if (thr_r != '0) begin
      thr_nxt = thr_r - 1'b1;
    end else begin
      thr_nxt = thr_r;
    end
  end

  amiv_cofactor u_cof (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (acc),
    .in_item (in_item),
    .cof_o   (cof)
  );

  amiv_det u_det (
    .clk   (clk),
    .rst_n (rst_n),
    .cof_i (cof),
    .det_o (det)
  );

  amiv_recip u_recip (
    .clk   (clk),
    .rst_n (rst_n),
    .det_i (det),
    .rcp_o (rcp)
  );

  amiv_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .rcp_i (rcp),
    .res_o (res)
  );

  // row serializer: the input throttle spaces the results, so a new one lands
  // at the earliest as the previous translation row goes out
  always_comb begin
    if (res.vld) begin
      ov_nxt  = 1'b1;
      row_nxt = '0;
    end else if (ov_r && row_r != amiv_pkg::ROW_TR) begin
      ov_nxt  = 1'b1;
      row_nxt = row_r + 1'b1;
    end else begin
      ov_nxt  = 1'b0;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      hold_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      ov_r  <= 1'b0;
      row_r <= '0;
    end else begin
      thr_r <= thr_nxt;
      ov_r  <= ov_nxt;
      row_r <= row_nxt;
    end
  end

  // row payload; singular rows are zero with saturated clear
  always_comb begin
    amiv_pkg::vec_t v;
    if (row_r == amiv_pkg::ROW_TR) begin
      v = hold_r.tr;
    end else begin
      v = hold_r.inv[row_r];
    end
    out_item.row_select = row_r;
    out_item.out_a      = hold_r.sing ? '0 : v[0];
    out_item.out_b      = hold_r.sing ? '0 : v[1];
    out_item.out_c      = hold_r.sing ? '0 : v[2];
    out_item.singular   = hold_r.sing;
    out_item.saturated  = ~hold_r.sing & (hold_r.dsat | hold_r.rsat[row_r]);
    out_item.last_row   = (row_r == amiv_pkg::ROW_TR);
  end

  assign out_valid = ov_r;

endmodule

@@ hw/rtl/amiv_cofactor.sv @@
// ============================================================================
// amiv_cofactor : adjugate entries
// Stage 1 forms the 18 cofactor products, stage 2 the differences.
// ============================================================================
module amiv_cofactor (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  amiv_pkg::in_t   in_item,
  output amiv_pkg::cof_t  cof_o
);

  amiv_pkg::mat_t            e;
  amiv_pkg::sq_t [2:0][2:0]  pa_nxt, pb_nxt, pa_r, pb_r;
  amiv_pkg::vec_t            erow_r, off_r;
  logic                      v1_r, v2_r;
  amiv_pkg::cof_t            cof_nxt, cof_r;

  always_comb begin
    e[0][0] = in_item.e11; e[0][1] = in_item.e12; e[0][2] = in_item.e13;
    e[1][0] = in_item.e21; e[1][1] = in_item.e22; e[1][2] = in_item.e23;
    e[2][0] = in_item.e31; e[2][1] = in_item.e32; e[2][2] = in_item.e33;
    pa_nxt[0][0] = amiv_pkg::mulq(e[1][1], e[2][2]);
    pb_nxt[0][0] = amiv_pkg::mulq(e[1][2], e[2][1]);
    pa_nxt[0][1] = amiv_pkg::mulq(e[0][2], e[2][1]);
    pb_nxt[0][1] = amiv_pkg::mulq(e[0][1], e[2][2]);
    pa_nxt[0][2] = amiv_pkg::mulq(e[0][1], e[1][2]);
    pb_nxt[0][2] = amiv_pkg::mulq(e[0][2], e[1][1]);
    pa_nxt[1][0] = amiv_pkg::mulq(e[1][2], e[2][0]);
    pb_nxt[1][0] = amiv_pkg::mulq(e[1][0], e[2][2]);
    pa_nxt[1][1] = amiv_pkg::mulq(e[0][0], e[2][2]);
    pb_nxt[1][1] = amiv_pkg::mulq(e[0][2], e[2][0]);
    pa_nxt[1][2] = amiv_pkg::mulq(e[0][2], e[1][0]);
    pb_nxt[1][2] = amiv_pkg::mulq(e[0][0], e[1][2]);
    pa_nxt[2][0] = amiv_pkg::mulq(e[1][0], e[2][1]);
    pb_nxt[2][0] = amiv_pkg::mulq(e[1][1], e[2][0]);
    pa_nxt[2][1] = amiv_pkg::mulq(e[0][1], e[2][0]);
    pb_nxt[2][1] = amiv_pkg::mulq(e[0][0], e[2][1]);
    pa_nxt[2][2] = amiv_pkg::mulq(e[0][0], e[1][1]);
    pb_nxt[2][2] = amiv_pkg::mulq(e[0][1], e[1][0]);
  end

  always_ff @(posedge clk) begin
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    erow_r <= e[0];
    off_r  <= {in_item.off_z, in_item.off_y, in_item.off_x};
  end

  // a*b - c*d, negate then add, each step clipped
  always_comb begin
    amiv_pkg::sq_t n, s;
    cof_nxt      = '0;
    cof_nxt.vld  = v1_r;
    cof_nxt.erow = erow_r;
    cof_nxt.off  = off_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        n = amiv_pkg::sat_neg(pb_r[r][c].val);
        s = amiv_pkg::sat_add(pa_r[r][c].val, n.val);
        cof_nxt.adj[r][c] = s.val;
        cof_nxt.rsat[r]   = cof_nxt.rsat[r] | pa_r[r][c].sat | pb_r[r][c].sat
                            | n.sat | s.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    cof_r <= cof_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    cof_o     = cof_r;
    cof_o.vld = v2_r;
  end

endmodule

@@ hw/rtl/amiv_det.sv @@
// ============================================================================
// amiv_det : determinant
// Stage 1 multiplies the first row by the first adjugate column, stage 2 sums.
// ============================================================================
module amiv_det (
  input  logic            clk,
  input  logic            rst_n,
  input  amiv_pkg::cof_t  cof_i,
  output amiv_pkg::det_t  det_o
);

  amiv_pkg::sq_t [2:0] d_nxt, d_r;
  amiv_pkg::cof_t      c_r;
  logic                v1_r, v2_r;
  amiv_pkg::det_t      det_nxt, det_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = amiv_pkg::mulq(cof_i.erow[k], cof_i.adj[k][0]);
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    c_r <= cof_i;
  end

  always_comb begin
    amiv_pkg::sq_t s1, s2;
    s1           = amiv_pkg::sat_add(d_r[0].val, d_r[1].val);
    s2           = amiv_pkg::sat_add(s1.val, d_r[2].val);
    det_nxt.vld  = v1_r;
    det_nxt.adj  = c_r.adj;
    det_nxt.rsat = c_r.rsat;
    det_nxt.off  = c_r.off;
    det_nxt.sing = (s2.val == '0);
    det_nxt.dneg = s2.val[amiv_pkg::EW-1];
    det_nxt.dmag = amiv_pkg::mag(s2.val);
    det_nxt.dsat = d_r[0].sat | d_r[1].sat | d_r[2].sat | s1.sat | s2.sat;
  end

  always_ff @(posedge clk) begin
    det_r <= det_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cof_i.vld;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    det_o     = det_r;
    det_o.vld = v2_r;
  end

endmodule

@@ hw/rtl/amiv_recip.sv @@
// ============================================================================
// amiv_recip : pipelined reciprocal of the determinant
// Restoring division of 2^(2*FB) by |det|, DIV_STEP quotient bits per stage.
// ============================================================================
module amiv_recip (
  input  logic            clk,
  input  logic            rst_n,
  input  amiv_pkg::det_t  det_i,
  output amiv_pkg::rcp_t  rcp_o
);

  typedef struct packed {
    amiv_pkg::det_t                 d;
    amiv_pkg::mag_t                 rem;
    logic [amiv_pkg::DIV_BITS-1:0]  quo;
  } dstg_t;

  dstg_t                         st_nxt [amiv_pkg::DIV_STG];
  dstg_t                         st_r   [amiv_pkg::DIV_STG];
  logic [amiv_pkg::DIV_STG-1:0]  sv_r;
  amiv_pkg::rcp_t                rcp_nxt, rcp_r;
  logic                          rv_r;

  always_comb begin
    dstg_t                 cur;
    logic [amiv_pkg::EW:0] r2;
    logic                  qb;
    int                    gi;
    for (int k = 0; k < amiv_pkg::DIV_STG; k++) begin
      if (k == 0) begin
        cur.d   = det_i;
        cur.rem = '0;
        cur.quo = '0;
      end else begin
        cur = st_r[k-1];
      end
      for (int j = 0; j < amiv_pkg::DIV_STEP; j++) begin
        gi = amiv_pkg::DIV_BITS - 1 - (k * amiv_pkg::DIV_STEP + j);
        if (gi >= 0) begin
          // only the top numerator bit is set
          r2 = {cur.rem, (gi == amiv_pkg::DIV_BITS - 1)};
          qb = (r2 >= {1'b0, cur.d.dmag});
          if (qb) begin
            r2 = r2 - {1'b0, cur.d.dmag};
          end
          cur.rem = r2[amiv_pkg::EW-1:0];
          cur.quo = {cur.quo[amiv_pkg::DIV_BITS-2:0], qb};
        end
      end
      st_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < amiv_pkg::DIV_STG; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  always_comb begin
    amiv_pkg::sq_t rc;
    dstg_t         lst;
    lst           = st_r[amiv_pkg::DIV_STG-1];
    rc            = amiv_pkg::lim_mag(lst.d.dneg, amiv_pkg::SW'(lst.quo));
    rcp_nxt.vld   = sv_r[amiv_pkg::DIV_STG-1];
    rcp_nxt.adj   = lst.d.adj;
    rcp_nxt.rsat  = lst.d.rsat;
    rcp_nxt.off   = lst.d.off;
    rcp_nxt.sing  = lst.d.sing;
    rcp_nxt.dsat  = lst.d.dsat | rc.sat;
    rcp_nxt.recip = rc.val;
  end

  always_ff @(posedge clk) begin
    rcp_r <= rcp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      rv_r <= 1'b0;
    end else begin
      sv_r <= {sv_r[amiv_pkg::DIV_STG-2:0], det_i.vld};
      rv_r <= sv_r[amiv_pkg::DIV_STG-1];
    end
  end

  always_comb begin
    rcp_o     = rcp_r;
    rcp_o.vld = rv_r;
  end

endmodule

@@ hw/rtl/amiv_scale.sv @@
// ============================================================================
// amiv_scale : inverse rows and new translation
// Scale adjugate by recip, multiply by old translation, sum, negate.
// ============================================================================
module amiv_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  amiv_pkg::rcp_t  rcp_i,
  output amiv_pkg::res_t  res_o
);

  // stage A: inverse entries
  amiv_pkg::mat_t  inva_nxt, inva_r;
  logic [2:0]      rsa_nxt, rsa_r;
  amiv_pkg::vec_t  offa_r;
  logic            singa_r, dsata_r;
  // stage B: translation products
  amiv_pkg::mat_t  tpb_nxt, tpb_r, invb_r;
  logic            tsb_nxt, tsb_r;
  logic [2:0]      rsb_r;
  logic            singb_r, dsatb_r;
  // stage C: column sums
  amiv_pkg::vec_t  sc_nxt, sc_r;
  logic            tsc_nxt, tsc_r;
  amiv_pkg::mat_t  invc_r;
  logic [2:0]      rsc_r;
  logic            singc_r, dsatc_r;
  // stage D: negate
  amiv_pkg::res_t  res_nxt, res_r;
  logic [3:0]      v_r;

  always_comb begin
    amiv_pkg::sq_t m;
    rsa_nxt = rcp_i.rsat;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m              = amiv_pkg::mulq(rcp_i.adj[r][c], rcp_i.recip);
        inva_nxt[r][c] = m.val;
        rsa_nxt[r]     = rsa_nxt[r] | m.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    inva_r  <= inva_nxt;
    rsa_r   <= rsa_nxt;
    offa_r  <= rcp_i.off;
    singa_r <= rcp_i.sing;
    dsata_r <= rcp_i.dsat;
  end

  always_comb begin
    amiv_pkg::sq_t m;
    tsb_nxt = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m             = amiv_pkg::mulq(offa_r[r], inva_r[r][c]);
        tpb_nxt[r][c] = m.val;
        tsb_nxt       = tsb_nxt | m.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    tpb_r   <= tpb_nxt;
    tsb_r   <= tsb_nxt;
    invb_r  <= inva_r;
    rsb_r   <= rsa_r;
    singb_r <= singa_r;
    dsatb_r <= dsata_r;
  end

  always_comb begin
    amiv_pkg::sq_t s1, s2;
    tsc_nxt = tsb_r;
    for (int c = 0; c < 3; c++) begin
      s1         = amiv_pkg::sat_add(tpb_r[0][c], tpb_r[1][c]);
      s2         = amiv_pkg::sat_add(s1.val, tpb_r[2][c]);
      sc_nxt[c]  = s2.val;
      tsc_nxt    = tsc_nxt | s1.sat | s2.sat;
    end
  end

  always_ff @(posedge clk) begin
    sc_r    <= sc_nxt;
    tsc_r   <= tsc_nxt;
    invc_r  <= invb_r;
    rsc_r   <= rsb_r;
    singc_r <= singb_r;
    dsatc_r <= dsatb_r;
  end

  always_comb begin
    amiv_pkg::sq_t n;
    logic          ts;
    ts = tsc_r | (|rsc_r);
    for (int c = 0; c < 3; c++) begin
      n             = amiv_pkg::sat_neg(sc_r[c]);
      res_nxt.tr[c] = n.val;
      ts            = ts | n.sat;
    end
    res_nxt.vld  = v_r[2];
    res_nxt.inv  = invc_r;
    res_nxt.sing = singc_r;
    res_nxt.dsat = dsatc_r;
    res_nxt.rsat = {ts, rsc_r};
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], rcp_i.vld};
    end
  end

  always_comb begin
    res_o     = res_r;
    res_o.vld = v_r[3];
  end

endmodule
